FILE: hdl/rtu_response_frame_checker_unit_defines.svh
// Assertion macros shared by the frame checker RTL.
// RFC_ASSERT checks a property outside reset, RFC_ASSERT_ALWAYS checks it on every edge.
`ifndef RTU_RESPONSE_FRAME_CHECKER_UNIT_DEFINES_SVH
`define RTU_RESPONSE_FRAME_CHECKER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RFC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("frame checker assertion failed");
`define RFC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("frame checker assertion failed");
`else
`define RFC_ASSERT(label, clk, rstn, prop)
`define RFC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: hdl/rtu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtu_pkg;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_LEN_ERR     = 2'd1,
        ST_SLAVE_FAULT = 2'd2,
        ST_CRC_ERR     = 2'd3
    } status_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_ADDRESS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FUNCTION_CODE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_LENGTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ECHO_LENGTH    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ECHO_PATTERN   = 3'd4;

    localparam logic [7:0]  RST_SLAVE_ADDRESS  = 8'd1;
    localparam logic [7:0]  RST_FUNCTION_CODE  = 8'd3;
    localparam logic [7:0]  RST_PAYLOAD_LENGTH = 8'd4;
    localparam logic [2:0]  RST_ECHO_LENGTH    = 3'd0;
    localparam logic [47:0] RST_ECHO_PATTERN   = 48'd0;

    localparam logic [2:0]  ECHO_MAX = 3'd6;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [7:0]  function_code;
        logic [7:0]  payload_length;
        logic [2:0]  echo_length;
        logic [47:0] echo_pattern;
    } cfg_t;

endpackage

`default_nettype wire

FILE: hdl/rtu_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module rtu_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rtu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rtu_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rtu_pkg::cfg_t                        cfg
);

    rtu_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Writes to an index outside the register list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slave_address  <= rtu_pkg::RST_SLAVE_ADDRESS;
            cfg_reg.function_code  <= rtu_pkg::RST_FUNCTION_CODE;
            cfg_reg.payload_length <= rtu_pkg::RST_PAYLOAD_LENGTH;
            cfg_reg.echo_length    <= rtu_pkg::RST_ECHO_LENGTH;
            cfg_reg.echo_pattern   <= rtu_pkg::RST_ECHO_PATTERN;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rtu_pkg::CFG_SLAVE_ADDRESS:  cfg_reg.slave_address  <= cfg_data[7:0];
                rtu_pkg::CFG_FUNCTION_CODE:  cfg_reg.function_code  <= cfg_data[7:0];
                rtu_pkg::CFG_PAYLOAD_LENGTH: cfg_reg.payload_length <= cfg_data[7:0];
                rtu_pkg::CFG_ECHO_LENGTH:    cfg_reg.echo_length    <= cfg_data[2:0];
                rtu_pkg::CFG_ECHO_PATTERN:   cfg_reg.echo_pattern   <= cfg_data[47:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rtu_crc16_byte.sv
`timescale 1ns / 1ps
`default_nettype none

module rtu_crc16_byte (
    input  wire logic [15:0] crc_in,
    input  wire logic [7:0]  data_in,
    output logic      [15:0] crc_out
);

    // Eight bit steps of the reflected CRC, unrolled.
    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ rtu_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

FILE: hdl/rtu_frame_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "rtu_response_frame_checker_unit_defines.svh"

module rtu_frame_core #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire rtu_pkg::cfg_t cfg,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               out_payload,
    output logic               out_last,
    output rtu_pkg::status_t   out_status
);

    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int W  = (PW > 9) ? PW : 9;
    localparam logic [W-1:0] MAX_W = W'(MAX_FRAME_BYTES);

    logic [PW-1:0] pos_reg, pos_next;
    logic [15:0]   crc_reg, crc_next;
    logic [15:0]   rx_crc_reg, rx_crc_next;
    logic          fault_reg, fault_next;

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_pay_reg;
    logic             out_last_reg;
    rtu_pkg::status_t out_status_reg;

    logic             take;
    logic [W-1:0]     pos_w, len_w, len_m1, len_m2, pay_idx;
    logic [2:0]       echo_n;
    logic [7:0]       echo_byte;
    logic [15:0]      crc_step;
    logic             pay;
    logic             crc_ok;
    logic             fault_hit;
    rtu_pkg::status_t status;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    assign pos_w   = W'(pos_reg);
    assign len_w   = W'(cfg.payload_length) + W'(4);
    assign len_m1  = len_w - W'(1);
    assign len_m2  = len_w - W'(2);
    assign pay_idx = pos_w - W'(2);
    assign echo_n  = (cfg.echo_length > rtu_pkg::ECHO_MAX) ? rtu_pkg::ECHO_MAX : cfg.echo_length;

    // The first echo byte sits in the top byte of the pattern.
    always_comb begin
        case (pay_idx[2:0])
            3'd0:    echo_byte = cfg.echo_pattern[47:40];
            3'd1:    echo_byte = cfg.echo_pattern[39:32];
            3'd2:    echo_byte = cfg.echo_pattern[31:24];
            3'd3:    echo_byte = cfg.echo_pattern[23:16];
            3'd4:    echo_byte = cfg.echo_pattern[15:8];
            3'd5:    echo_byte = cfg.echo_pattern[7:0];
            default: echo_byte = 8'h00;
        endcase
    end

    rtu_crc16_byte u_crc (
        .crc_in  (crc_reg),
        .data_in (in_byte),
        .crc_out (crc_step)
    );

    always_comb begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        rx_crc_next = rx_crc_reg;
        fault_hit   = 1'b0;
        pay         = 1'b0;
        crc_ok      = 1'b0;
        status      = rtu_pkg::ST_OK;

        // Bytes at the saturated position or past the expected length are ignored.
        if (pos_w < MAX_W && pos_w < len_w) begin
            if (pos_w < len_m2) begin
                crc_next = crc_step;
                if (pos_w == W'(0)) begin
                    fault_hit = (in_byte != cfg.slave_address);
                end else if (pos_w == W'(1)) begin
                    fault_hit = (in_byte != cfg.function_code);
                end else begin
                    pay = 1'b1;
                    if (pay_idx < W'(echo_n)) begin
                        fault_hit = (in_byte != echo_byte);
                    end
                end
            end else if (pos_w == len_m2) begin
                rx_crc_next = {rx_crc_reg[15:8], in_byte};
            end else begin
                rx_crc_next = {in_byte, rx_crc_reg[7:0]};
                crc_ok      = ({in_byte, rx_crc_reg[7:0]} == crc_reg);
            end
        end

        fault_next = fault_reg | fault_hit;

        if (in_last) begin
            if (len_w > MAX_W || pos_w != len_m1) begin
                status = rtu_pkg::ST_LEN_ERR;
            end else if (fault_next) begin
                status = rtu_pkg::ST_SLAVE_FAULT;
            end else if (!crc_ok) begin
                status = rtu_pkg::ST_CRC_ERR;
            end else begin
                status = rtu_pkg::ST_OK;
            end
            pos_next    = '0;
            crc_next    = rtu_pkg::CRC_INIT;
            rx_crc_next = 16'h0000;
            fault_next  = 1'b0;
        end else if (pos_w < MAX_W) begin
            pos_next = pos_reg + PW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            crc_reg    <= rtu_pkg::CRC_INIT;
            rx_crc_reg <= 16'h0000;
            fault_reg  <= 1'b0;
        end else if (take) begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            rx_crc_reg <= rx_crc_next;
            fault_reg  <= fault_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_byte_reg   <= in_byte;
            out_pay_reg    <= pay;
            out_last_reg   <= in_last;
            out_status_reg <= status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign out_payload = out_pay_reg;
    assign out_last    = out_last_reg;
    assign out_status  = out_status_reg;

    `RFC_ASSERT(a_rearm_on_last, aclk, aresetn, (take && in_last) |=> (pos_reg == '0 && crc_reg == rtu_pkg::CRC_INIT && !fault_reg))
    `RFC_ASSERT(a_pos_saturates, aclk, aresetn, W'(pos_reg) <= MAX_W)
    `RFC_ASSERT(a_status_only_on_last, aclk, aresetn, (out_valid_reg && !out_last_reg) |-> (out_status_reg == rtu_pkg::ST_OK))
    `RFC_ASSERT(a_no_payload_when_saturated, aclk, aresetn, (take && W'(pos_reg) >= MAX_W) |=> !out_pay_reg)
    `RFC_ASSERT_ALWAYS(a_reset_empties_output, aclk, !aresetn |=> !out_valid_reg)

endmodule

`default_nettype wire

FILE: hdl/rtu_response_frame_checker_unit.sv
// Path: a word accepted on the s_ side reaches the m_ side through the input register,
// then the check logic and CRC byte step into the result register.
// Throughput: one word per cycle; the input stalls only while the result register is held.
// Reset: aresetn is synchronous and active low; it empties both registers, rearms the
// frame state (position 0, CRC 0xFFFF) and restores the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

module rtu_response_frame_checker_unit #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rtu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rtu_pkg::CFG_DATA_W-1:0]  cfg_data,
    // received bytes
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,  // [7:0] rx_byte
    input  wire logic                            s_tlast,  // frame_end
    // checked bytes
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [7:0]                           m_tdata,  // [7:0] payload_byte
    output logic                                 m_tlast,  // frame_done
    output logic [2:0]                           m_tuser   // [0] payload_valid, [2:1] frame_status
);

    rtu_pkg::cfg_t    cfg;
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic             core_ready;
    logic             core_payload;
    rtu_pkg::status_t core_status;

    rtu_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign s_tready = !in_valid_reg || core_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    rtu_frame_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_valid    (in_valid_reg),
        .in_ready    (core_ready),
        .in_byte     (in_byte_reg),
        .in_last     (in_last_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (m_tdata),
        .out_payload (core_payload),
        .out_last    (m_tlast),
        .out_status  (core_status)
    );

    assign m_tuser = {core_status, core_payload};

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int FRAME_LIMIT = 256;

    // Indexes beyond the register list; writes there must change nothing.
    localparam logic [rtu_pkg::CFG_INDEX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [rtu_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    typedef enum int {
        FK_GOOD,
        FK_BAD_ADDR,
        FK_BAD_FUNC,
        FK_BAD_ECHO,
        FK_BAD_CRC,
        FK_SHORT,
        FK_LONG,
        FK_NOISE
    } frame_kind_t;

    typedef struct packed {
        logic [7:0]       data;
        logic             pay;
        logic             done;
        rtu_pkg::status_t status;
    } checked_word_t;

    function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
        c = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ rtu_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    class frame_check_board;
        logic [7:0]    addr_reg;
        logic [7:0]    func_reg;
        logic [7:0]    plen_reg;
        logic [2:0]    echo_len_reg;
        logic [47:0]   echo_pat_reg;
        int unsigned   pos;
        logic [15:0]   crc_acc;
        logic [15:0]   crc_rx;
        bit            faulted;
        checked_word_t expected_q[$];
        int            errors;
        int            words_checked;
        int            status_seen[4];

        function new();
            addr_reg     = rtu_pkg::RST_SLAVE_ADDRESS;
            func_reg     = rtu_pkg::RST_FUNCTION_CODE;
            plen_reg     = rtu_pkg::RST_PAYLOAD_LENGTH;
            echo_len_reg = rtu_pkg::RST_ECHO_LENGTH;
            echo_pat_reg = rtu_pkg::RST_ECHO_PATTERN;
            errors       = 0;
            words_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            rearm();
        endfunction

        function void rearm();
            pos     = 0;
            crc_acc = rtu_pkg::CRC_INIT;
            crc_rx  = 16'h0000;
            faulted = 1'b0;
        endfunction

        function void write_reg(logic [rtu_pkg::CFG_INDEX_W-1:0] idx,
                                logic [rtu_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                rtu_pkg::CFG_SLAVE_ADDRESS:  addr_reg     = val[7:0];
                rtu_pkg::CFG_FUNCTION_CODE:  func_reg     = val[7:0];
                rtu_pkg::CFG_PAYLOAD_LENGTH: plen_reg     = val[7:0];
                rtu_pkg::CFG_ECHO_LENGTH:    echo_len_reg = val[2:0];
                rtu_pkg::CFG_ECHO_PATTERN:   echo_pat_reg = val[47:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Works out the checked word that one accepted input byte causes.
        function void note_word(logic [7:0] b, bit is_last);
            int unsigned   len;
            int unsigned   p;
            int unsigned   echo_n;
            int unsigned   idx;
            bit            crc_good;
            checked_word_t w;
            len      = plen_reg + 4;
            p        = pos;
            echo_n   = (echo_len_reg > rtu_pkg::ECHO_MAX) ? rtu_pkg::ECHO_MAX : echo_len_reg;
            crc_good = 1'b0;
            w.data   = b;
            w.pay    = 1'b0;
            w.done   = is_last;
            w.status = rtu_pkg::ST_OK;
            if (p < FRAME_LIMIT && p < len) begin
                if (p < len - 2) begin
                    crc_acc = crc16_byte(crc_acc, b);
                    if (p == 0) begin
                        if (b != addr_reg) faulted = 1'b1;
                    end else if (p == 1) begin
                        if (b != func_reg) faulted = 1'b1;
                    end else begin
                        idx   = p - 2;
                        w.pay = 1'b1;
                        if (idx < echo_n && b != echo_pat_reg[47 - 8 * idx -: 8]) faulted = 1'b1;
                    end
                end else if (p == len - 2) begin
                    crc_rx[7:0] = b;
                end else begin
                    crc_rx[15:8] = b;
                    crc_good     = (crc_rx == crc_acc);
                end
            end
            if (is_last) begin
                if (len > FRAME_LIMIT || p != len - 1) w.status = rtu_pkg::ST_LEN_ERR;
                else if (faulted) w.status = rtu_pkg::ST_SLAVE_FAULT;
                else if (!crc_good) w.status = rtu_pkg::ST_CRC_ERR;
                rearm();
            end else if (pos < FRAME_LIMIT) begin
                pos++;
            end
            expected_q.push_back(w);
        endfunction

        function void check_word(logic [7:0] data, logic done, logic [2:0] user);
            checked_word_t w;
            if (expected_q.size() == 0) begin
                $error("unexpected word: payload_byte %02h, frame_done %0b, tuser %03b",
                       data, done, user);
                errors++;
                return;
            end
            w = expected_q.pop_front();
            words_checked++;
            if (data !== w.data) begin
                $error("payload_byte: expected %02h, actual %02h", w.data, data);
                errors++;
            end
            if (user[0] !== w.pay) begin
                $error("payload_valid: expected %0b, actual %0b", w.pay, user[0]);
                errors++;
            end
            if (done !== w.done) begin
                $error("frame_done: expected %0b, actual %0b", w.done, done);
                errors++;
            end
            if (user[2:1] !== w.status) begin
                $error("frame_status: expected %0d, actual %0d", w.status, user[2:1]);
                errors++;
            end
            if (w.done) status_seen[w.status]++;
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [rtu_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rtu_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata   = 8'h00;
    logic                            s_tlast   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b1;
    logic [7:0]                      m_tdata;
    logic                            m_tlast;
    logic [2:0]                      m_tuser;

    frame_check_board sb;
    bit               calm = 1'b0;
    int               stall_left = 0;
    int               words_sent = 0;
    int               frames_sent = 0;
    int               settings_done = 0;

    rtu_response_frame_checker_unit #(
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

    // Result side: check every accepted word and stall in short random bursts.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast, m_tuser);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_word(input logic [7:0] b, input bit is_last);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(b, is_last);
        words_sent++;
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [rtu_pkg::CFG_INDEX_W-1:0] idx, input logic [47:0] val,
                             input int width);
        logic [63:0] junk;
        logic [47:0] word;
        junk = {$urandom, $urandom};
        word = (width >= 48) ? val : ((junk[47:0] << width) | val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, word);
    endtask

    task automatic configure(input logic [7:0] a, input logic [7:0] f, input logic [7:0] p,
                             input logic [2:0] el, input logic [47:0] ep);
        logic [63:0] junk;
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        write_reg(rtu_pkg::CFG_SLAVE_ADDRESS, a, 8);
        write_reg(rtu_pkg::CFG_FUNCTION_CODE, f, 8);
        write_reg(rtu_pkg::CFG_PAYLOAD_LENGTH, p, 8);
        write_reg(rtu_pkg::CFG_ECHO_LENGTH, el, 3);
        write_reg(rtu_pkg::CFG_ECHO_PATTERN, ep, 48);
        if ($urandom_range(0, 3) == 0) begin
            junk = {$urandom, $urandom};
            write_reg(3'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), junk[47:0], 48);
        end
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    // Builds one response frame under the current settings, spoils it as asked, sends it.
    task automatic send_frame(input frame_kind_t kind);
        logic [7:0]  q[$];
        logic [15:0] c;
        logic [7:0]  nz;
        int          len;
        int          echo_n;
        int          n;
        len    = sb.plen_reg + 4;
        echo_n = (sb.echo_len_reg > rtu_pkg::ECHO_MAX) ? rtu_pkg::ECHO_MAX : sb.echo_len_reg;
        nz     = 8'($urandom_range(1, 255));
        if (kind == FK_NOISE) begin
            n = $urandom_range(1, len + 3);
            repeat (n) q.push_back(8'($urandom));
        end else begin
            q.push_back(sb.addr_reg);
            q.push_back(sb.func_reg);
            for (int i = 0; i < sb.plen_reg; i++) begin
                q.push_back(i < echo_n ? sb.echo_pat_reg[47 - 8 * i -: 8] : 8'($urandom));
            end
            case (kind)
                FK_BAD_ADDR: begin
                    q[0] = q[0] ^ nz;
                end
                FK_BAD_FUNC: begin
                    q[1] = q[1] ^ nz;
                end
                FK_BAD_ECHO: begin
                    n = (echo_n < sb.plen_reg) ? echo_n : sb.plen_reg;
                    if (n > 0) q[2 + $urandom_range(0, n - 1)] ^= nz;
                    else q[0] = q[0] ^ nz;
                end
                default: ;
            endcase
            c = rtu_pkg::CRC_INIT;
            foreach (q[i]) c = crc16_byte(c, q[i]);
            q.push_back(c[7:0]);
            q.push_back(c[15:8]);
            case (kind)
                FK_BAD_CRC: begin
                    n    = q.size() - 1 - $urandom_range(0, 1);
                    q[n] = q[n] ^ (8'h01 << $urandom_range(0, 7));
                end
                FK_SHORT: begin
                    n = $urandom_range(1, len - 1);
                    while (q.size() > n) void'(q.pop_back());
                end
                FK_LONG: begin
                    repeat ($urandom_range(1, 4)) q.push_back(8'($urandom));
                end
                default: ;
            endcase
        end
        foreach (q[i]) send_word(q[i], i == q.size() - 1);
        frames_sent++;
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    initial begin
        int          r;
        int          nframes;
        logic [63:0] w;
        logic [7:0]  p;
        logic [47:0] ep;
        frame_kind_t kind;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, starting from the reset settings.
        send_frame(FK_GOOD);
        send_frame(FK_BAD_CRC);
        send_word(8'hFF, 1'b1);
        configure(8'h00, 8'hFF, 8'd0, 3'd7, 48'hFFFF_FFFF_FFFF);
        send_frame(FK_GOOD);
        send_frame(FK_BAD_ADDR);

        // Longest legal frame with extra bytes behind it, so the position saturates.
        w = {$urandom, $urandom};
        configure(pick_byte(), pick_byte(), 8'd252, 3'd6, w[47:0]);
        send_frame(FK_LONG);
        // Expected length beyond the buffer: every frame must end in a length error.
        w = {$urandom, $urandom};
        configure(pick_byte(), pick_byte(), 8'($urandom_range(253, 255)),
                  3'($urandom_range(0, 7)), w[47:0]);
        send_word(sb.addr_reg, 1'b0);
        send_word(sb.func_reg, 1'b0);
        send_word(pick_byte(), 1'b1);

        while (words_sent < 600) begin
            calm = words_sent >= 520;
            w    = {$urandom, $urandom};
            ep   = ($urandom_range(0, 9) == 0) ? 48'hFFFF_FFFF_FFFF :
                   ($urandom_range(0, 9) == 0) ? 48'h0 : w[47:0];
            p    = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 12));
            configure(pick_byte(), pick_byte(), p, 3'($urandom_range(0, 7)), ep);
            nframes = $urandom_range(3, 8);
            repeat (nframes) begin
                r = $urandom_range(0, 99);
                if (r < 55) kind = FK_GOOD;
                else if (r < 63) kind = FK_BAD_ADDR;
                else if (r < 69) kind = FK_BAD_FUNC;
                else if (r < 77) kind = FK_BAD_ECHO;
                else if (r < 85) kind = FK_BAD_CRC;
                else if (r < 91) kind = FK_SHORT;
                else if (r < 96) kind = FK_LONG;
                else kind = FK_NOISE;
                send_frame(kind);
            end
        end
        s_tvalid <= 1'b0;

        for (int k = 0; k < 2000 && sb.pending() != 0; k++) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.pending() != 0) begin
            $error("%0d checked words never arrived", sb.pending());
            sb.errors++;
        end

        $display("summary: %0d words in %0d frames checked over %0d register settings",
                 sb.words_checked, frames_sent, settings_done);
        $display("summary: status ok %0d, length %0d, slave fault %0d, crc %0d",
                 sb.status_seen[rtu_pkg::ST_OK], sb.status_seen[rtu_pkg::ST_LEN_ERR],
                 sb.status_seen[rtu_pkg::ST_SLAVE_FAULT], sb.status_seen[rtu_pkg::ST_CRC_ERR]);
        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
